FILE: rtl/tcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants of the console line cooker.
// ----------------------------------------------------------------------------
package tcl_pkg;

	localparam int LINE_BYTES = 4096;
	localparam int ADDR_W     = $clog2(LINE_BYTES);
	localparam int LEN_W      = $clog2(LINE_BYTES + 1);

	typedef enum logic [1:0] {
		OP_RX     = 2'd0,
		OP_HANGUP = 2'd1,
		OP_READ   = 2'd2,
		OP_BAD    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ACCEPT = 3'd0,
		KIND_ECHO   = 3'd1,
		KIND_DATA   = 3'd2,
		KIND_EOF    = 3'd3,
		KIND_WAIT   = 3'd4,
		KIND_REFUSE = 3'd5
	} kind_t;

	localparam logic [7:0] CH_IAC   = 8'hff;
	localparam logic [7:0] CH_WILL  = 8'hfb;
	localparam logic [7:0] CH_DONT  = 8'hfe;
	localparam logic [7:0] CH_SB    = 8'hfa;
	localparam logic [7:0] CH_SE    = 8'hf0;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_EOT   = 8'h04;

	// result group of one input item, handed from the control stage to the output stage
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [1:0] last_idx;
		logic       use_mem;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} desc_t;

endpackage
`default_nettype wire

FILE: rtl/tcl_line_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcl_line_ram
// Simple dual-port line store, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcl_line_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tcl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcl_ctrl
// Telnet command filter, line editing state and store access; first stage.
// ----------------------------------------------------------------------------
module tcl_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,
	input  wire logic [1:0]            s_tuser,
	input  wire logic                  adv,
	output tcl_pkg::desc_t             desc,
	output logic                       mem_we,
	output logic [tcl_pkg::ADDR_W-1:0] mem_waddr,
	output logic [7:0]                 mem_wdata,
	output logic                       mem_re,
	output logic [tcl_pkg::ADDR_W-1:0] mem_raddr
);
	import tcl_pkg::*;

	typedef enum logic [2:0] {
		TS_DATA,
		TS_IAC,
		TS_OPT,
		TS_SB,
		TS_SB_IAC
	} ts_t;

	localparam logic [LEN_W-1:0] FULL = LEN_W'(LINE_BYTES);

	ts_t             ts_q, ts_n;
	logic            raw_q;
	logic            acr_q, acr_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [LEN_W-1:0] rp_q, rp_n;
	logic            ready_q, ready_n;
	logic            eof_q, eof_n;
	logic            gone_q, gone_n;

	logic            valid_s1;
	desc_t           pay_s1, pay_c;
	logic            accept;
	logic            is_data;
	logic [7:0]      db;
	logic            we_c;
	logic [7:0]      wd_c;
	logic            re_c;
	op_t             op;

	assign op       = op_t'(s_tuser);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		ts_n    = ts_q;
		acr_n   = acr_q;
		len_n   = len_q;
		rp_n    = rp_q;
		ready_n = ready_q;
		eof_n   = eof_q;
		gone_n  = gone_q;
		we_c    = 1'b0;
		wd_c    = s_tdata;
		re_c    = 1'b0;
		is_data = 1'b0;
		db      = s_tdata;
		pay_c   = '0;
		pay_c.valid = 1'b1;
		pay_c.kind  = KIND_ACCEPT;

		case (op)
			OP_RX: begin
				if (gone_q || ready_q) begin
					pay_c.kind = KIND_REFUSE;
				end else begin
					unique case (ts_q)
						TS_DATA: begin
							if (s_tdata == CH_IAC) ts_n = TS_IAC;
							else is_data = 1'b1;
						end
						TS_IAC: begin
							ts_n = TS_DATA;
							if (s_tdata == CH_IAC) is_data = 1'b1;
							else if (s_tdata >= CH_WILL && s_tdata <= CH_DONT) ts_n = TS_OPT;
							else if (s_tdata == CH_SB) ts_n = TS_SB;
						end
						TS_OPT: ts_n = TS_DATA;
						TS_SB: begin
							if (s_tdata == CH_IAC) ts_n = TS_SB_IAC;
						end
						TS_SB_IAC: ts_n = (s_tdata == CH_SE) ? TS_DATA : TS_SB;
						default: ts_n = TS_DATA;
					endcase
				end

				if (is_data) begin
					acr_n = 1'b0;
					if (acr_q && (db == CH_LF || db == CH_NUL)) begin
						pay_c.kind = KIND_ACCEPT;
					end else if (raw_q) begin
						if (len_q < FULL) begin
							we_c  = 1'b1;
							len_n = len_q + 1'b1;
						end
						ready_n = 1'b1;
					end else if (db == CH_CR || db == CH_LF) begin
						acr_n = (db == CH_CR);
						wd_c  = CH_LF;
						if (len_q < FULL) begin
							we_c  = 1'b1;
							len_n = len_q + 1'b1;
						end
						ready_n        = 1'b1;
						pay_c.kind     = KIND_ECHO;
						pay_c.last_idx = 2'd1;
						pay_c.b0       = CH_CR;
						pay_c.b1       = CH_LF;
					end else if (db == CH_NUL) begin
						pay_c.kind = KIND_ACCEPT;
					end else if (db == CH_DEL || db == CH_BS) begin
						if (len_q != '0) begin
							len_n          = len_q - 1'b1;
							pay_c.kind     = KIND_ECHO;
							pay_c.last_idx = 2'd2;
							pay_c.b0       = CH_BS;
							pay_c.b1       = CH_SPACE;
							pay_c.b2       = CH_BS;
						end
					end else if (db == CH_EOT) begin
						if (len_q == '0) eof_n = 1'b1;
						else ready_n = 1'b1;
					end else if (len_q < FULL) begin
						we_c  = 1'b1;
						len_n = len_q + 1'b1;
						if (db >= CH_SPACE || db == CH_TAB) begin
							pay_c.kind = KIND_ECHO;
							pay_c.b0   = db;
						end
					end
				end
			end
			OP_HANGUP: begin
				gone_n = 1'b1;
				if (len_q != '0) ready_n = 1'b1;
			end
			OP_READ: begin
				if (eof_q) begin
					eof_n      = 1'b0;
					pay_c.kind = KIND_EOF;
				end else if (ready_q && rp_q < len_q) begin
					re_c          = 1'b1;
					pay_c.kind    = KIND_DATA;
					pay_c.use_mem = 1'b1;
					if (rp_q + 1'b1 >= len_q) begin
						ready_n = 1'b0;
						len_n   = '0;
						rp_n    = '0;
					end else begin
						rp_n = rp_q + 1'b1;
					end
				end else begin
					if (ready_q) begin
						ready_n = 1'b0;
						len_n   = '0;
						rp_n    = '0;
					end
					pay_c.kind = gone_q ? KIND_EOF : KIND_WAIT;
				end
			end
			default: pay_c.kind = KIND_REFUSE;
		endcase
	end

	assign mem_we    = accept && we_c;
	assign mem_waddr = len_q[ADDR_W-1:0];
	assign mem_wdata = wd_c;
	assign mem_re    = accept && re_c;
	assign mem_raddr = rp_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q    <= TS_DATA;
			raw_q   <= 1'b0;
			acr_q   <= 1'b0;
			len_q   <= '0;
			rp_q    <= '0;
			ready_q <= 1'b0;
			eof_q   <= 1'b0;
			gone_q  <= 1'b0;
		end else begin
			if (cfg_we) raw_q <= cfg_wdata;
			if (accept) begin
				ts_q    <= ts_n;
				acr_q   <= acr_n;
				len_q   <= len_n;
				rp_q    <= rp_n;
				ready_q <= ready_n;
				eof_q   <= eof_n;
				gone_q  <= gone_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) pay_s1 <= pay_c;
	end

	always_comb begin
		desc       = pay_s1;
		desc.valid = valid_s1;
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= FULL) else $error("line length beyond capacity");

	a_rp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ready_q |-> rp_q == '0) else $error("read position moved without a line");

	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q != '0 |-> rp_q < len_q) else $error("read position past line end");

	a_hold_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> !s_tready) else $error("input taken while stage busy");

endmodule
`default_nettype wire

FILE: rtl/tcl_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcl_out
// Output stage: holds one result group and sends it one result per transfer.
// ----------------------------------------------------------------------------
module tcl_out (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tcl_pkg::desc_t desc,
	input  wire logic [7:0]     mem_rdata,
	output logic                adv,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [7:0]          m_tdata,
	output logic [2:0]          m_tuser,
	output logic                m_tlast
);
	import tcl_pkg::*;

	logic       valid_s2;
	kind_t      kind_s2;
	logic [1:0] idx_s2;
	logic [1:0] last_s2;
	logic [7:0] byte_s2 [3];
	logic       is_last;

	assign is_last  = (idx_s2 == last_s2);
	assign adv      = !valid_s2 || (m_tready && is_last);
	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tlast  = is_last;
	assign m_tdata  = byte_s2[idx_s2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (adv) begin
			valid_s2 <= desc.valid;
			idx_s2   <= '0;
		end else if (m_tready) begin
			idx_s2 <= idx_s2 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && desc.valid) begin
			kind_s2    <= desc.kind;
			last_s2    <= desc.last_idx;
			byte_s2[0] <= desc.use_mem ? mem_rdata : desc.b0;
			byte_s2[1] <= desc.b1;
			byte_s2[2] <= desc.b2;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_s2 <= last_s2) else $error("result index past group end");

	a_multi_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2 != 2'd0) |-> kind_s2 == KIND_ECHO)
		else $error("multi-result group that is not echo");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && m_tready && !is_last) |=> (valid_s2 && idx_s2 == $past(idx_s2) + 2'd1))
		else $error("result group did not advance");

endmodule
`default_nettype wire

FILE: rtl/telnet_console_line_cooker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// telnet_console_line_cooker
// Telnet command filter and cooked/raw console line discipline.
//
// Slave stream: tuser = operation (received byte, disconnect, read request),
// tdata = received byte. Master stream: tuser = result kind, tdata = echo or
// line byte, tlast on the final result of each input item. cfg_we/cfg_wdata
// write raw_mode; write only while the block is idle.
// An item is taken into the control stage, where the line state is updated
// and the line store is written or read; its results are registered there
// and in the output stage before the master port. One item per cycle is
// taken while each gives one result and the master does not stall; an item
// with n results (echo of CR LF or BS SP BS) holds the output stage until
// all n are sent. The control stage covers the registered store read.
// A stalled master holds its result and lets one more item into the control
// stage before the slave side stalls too.
// Reset clears the telnet and line state at once; the store content is not
// cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module telnet_console_line_cooker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // rx_byte [7:0]
	input  wire logic [1:0] s_tuser,   // operation [1:0]
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // data_byte [7:0]
	output logic [2:0]      m_tuser,   // kind [2:0]
	output logic            m_tlast
);
	import tcl_pkg::*;

	desc_t             desc;
	logic              adv;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_rdata;

	tcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.adv       (adv),
		.desc      (desc),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	tcl_line_ram #(
		.DEPTH (LINE_BYTES),
		.WIDTH (8)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	tcl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc      (desc),
		.mem_rdata (mem_rdata),
		.adv       (adv),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telnet console line cooker.
//
// A queue of link items (received bytes, reads, disconnects and bad opcodes)
// feeds a stream driver. Each accepted transfer runs through a line-discipline
// predictor that keeps its own telnet and line state, and the results it
// computes are matched against the master stream in order. The run walks
// directed cases, random cooked lines with telnet commands, raw mode and a
// final disconnect, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

	import tcl_pkg::*;

	localparam logic [7:0] CH_NOP = 8'hf1;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [2:0] {
		TN_DATA,
		TN_CMD,
		TN_OPTION,
		TN_SUBNEG,
		TN_SUBNEG_IAC
	} tn_state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] b;
	} link_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       is_last;
	} cooked_res_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'h00;
	logic [1:0] s_tuser   = OP_RX;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	link_item_t  link_items [$];
	cooked_res_t due_results [$];
	cooked_res_t step_results [$];

	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_cnt  = 0;
	int errors    = 0;
	int n_items   = 0;
	int n_results = 0;
	int kind_seen [6];

	// line discipline state
	logic       raw_mode_q  = 1'b0;
	tn_state_t  tn_state    = TN_DATA;
	logic       after_cr    = 1'b0;
	logic [7:0] line_buf [LINE_BYTES];
	int         line_len    = 0;
	int         rd_pos      = 0;
	logic       line_rdy    = 1'b0;
	logic       eof_pending = 1'b0;
	logic       hung_up     = 1'b0;

	telnet_console_line_cooker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // rx_byte [7:0]
		.s_tuser  (s_tuser),   // operation [1:0]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // data_byte [7:0]
		.m_tuser  (m_tuser),   // kind [2:0]
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	function automatic void note_result(kind_t k, logic [7:0] d);
		step_results.push_back('{k, d, 1'b0});
	endfunction

	function automatic void store_byte(logic [7:0] b);
		if (line_len < LINE_BYTES) begin
			line_buf[line_len] = b;
			line_len++;
		end
	endfunction

	function automatic void cook_data(logic [7:0] b);
		if (after_cr) begin
			after_cr = 1'b0;
			if (b == CH_LF || b == CH_NUL) begin
				note_result(KIND_ACCEPT, CH_NUL);
				return;
			end
		end
		if (raw_mode_q) begin
			store_byte(b);
			line_rdy = 1'b1;
			note_result(KIND_ACCEPT, CH_NUL);
			return;
		end
		if (b == CH_CR || b == CH_LF) begin
			after_cr = (b == CH_CR);
			store_byte(CH_LF);
			line_rdy = 1'b1;
			note_result(KIND_ECHO, CH_CR);
			note_result(KIND_ECHO, CH_LF);
			return;
		end
		if (b == CH_NUL) begin
			note_result(KIND_ACCEPT, CH_NUL);
			return;
		end
		if (b == CH_DEL || b == CH_BS) begin
			if (line_len > 0) begin
				line_len--;
				note_result(KIND_ECHO, CH_BS);
				note_result(KIND_ECHO, CH_SPACE);
				note_result(KIND_ECHO, CH_BS);
			end else begin
				note_result(KIND_ACCEPT, CH_NUL);
			end
			return;
		end
		if (b == CH_EOT) begin
			if (line_len == 0)
				eof_pending = 1'b1;
			else
				line_rdy = 1'b1;
			note_result(KIND_ACCEPT, CH_NUL);
			return;
		end
		if (line_len < LINE_BYTES) begin
			store_byte(b);
			if (b >= CH_SPACE || b == CH_TAB) begin
				note_result(KIND_ECHO, b);
				return;
			end
		end
		note_result(KIND_ACCEPT, CH_NUL);
	endfunction

	function automatic void take_rx(logic [7:0] b);
		if (hung_up || line_rdy) begin
			note_result(KIND_REFUSE, CH_NUL);
			return;
		end
		case (tn_state)
			TN_DATA: begin
				if (b == CH_IAC) begin
					tn_state = TN_CMD;
					note_result(KIND_ACCEPT, CH_NUL);
				end else begin
					cook_data(b);
				end
			end
			TN_CMD: begin
				tn_state = TN_DATA;
				if (b == CH_IAC) begin
					cook_data(b);
				end else begin
					if (b >= CH_WILL && b <= CH_DONT)
						tn_state = TN_OPTION;
					else if (b == CH_SB)
						tn_state = TN_SUBNEG;
					note_result(KIND_ACCEPT, CH_NUL);
				end
			end
			TN_OPTION: begin
				tn_state = TN_DATA;
				note_result(KIND_ACCEPT, CH_NUL);
			end
			TN_SUBNEG: begin
				if (b == CH_IAC)
					tn_state = TN_SUBNEG_IAC;
				note_result(KIND_ACCEPT, CH_NUL);
			end
			default: begin
				tn_state = (b == CH_SE) ? TN_DATA : TN_SUBNEG;
				note_result(KIND_ACCEPT, CH_NUL);
			end
		endcase
	endfunction

	function automatic void take_read();
		logic [7:0] b;
		if (eof_pending) begin
			eof_pending = 1'b0;
			note_result(KIND_EOF, CH_NUL);
			return;
		end
		if (line_rdy && rd_pos < line_len) begin
			b = line_buf[rd_pos];
			rd_pos++;
			if (rd_pos >= line_len) begin
				line_rdy = 1'b0;
				line_len = 0;
				rd_pos   = 0;
			end
			note_result(KIND_DATA, b);
			return;
		end
		if (line_rdy) begin
			line_rdy = 1'b0;
			line_len = 0;
			rd_pos   = 0;
		end
		if (hung_up)
			note_result(KIND_EOF, CH_NUL);
		else
			note_result(KIND_WAIT, CH_NUL);
	endfunction

	function automatic void cook_item(link_item_t it);
		step_results.delete();
		case (it.op)
			OP_RX:     take_rx(it.b);
			OP_HANGUP: begin
				hung_up = 1'b1;
				if (line_len > 0)
					line_rdy = 1'b1;
				note_result(KIND_ACCEPT, CH_NUL);
			end
			OP_READ:   take_read();
			default:   note_result(KIND_REFUSE, CH_NUL);
		endcase
		step_results[step_results.size() - 1].is_last = 1'b1;
		foreach (step_results[i])
			due_results.push_back(step_results[i]);
	endfunction

	always @(posedge clk) begin : drive_p
		logic busy;
		busy = s_tvalid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				cook_item(link_items[0]);
				void'(link_items.pop_front());
				n_items++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (link_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= link_items[0].b;
					s_tuser  <= link_items[0].op;
				end else begin
					s_tvalid <= 1'b0;
					s_tdata  <= 8'($urandom);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req != hold_seen) begin
			hold_cnt  <= HOLD_CYCLES;
			hold_seen <= hold_req;
		end
	end

	always @(posedge clk) begin : watch_p
		cooked_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result kind %0d byte %02h last %0b",
						$time, m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					want = due_results.pop_front();
					n_results++;
					kind_seen[want.kind]++;
					if (m_tuser !== want.kind || m_tdata !== want.data ||
							m_tlast !== want.is_last) begin
						$display("%0t: mismatch, expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
							$time, want.kind, want.data, want.is_last,
							m_tuser, m_tdata, m_tlast);
						errors++;
					end
				end
			end
			m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void put_item(op_t op, logic [7:0] b);
		link_items.push_back('{op, b});
	endfunction

	function automatic void put_reads(int n);
		repeat (n)
			put_item(OP_READ, 8'($urandom));
	endfunction

	function automatic void put_rx(logic [7:0] b);
		put_item(OP_RX, b);
	endfunction

	function automatic void gen_noise();
		case ($urandom_range(0, 2))
			0:       put_rx(8'($urandom));
			1:       put_item(OP_READ, 8'($urandom));
			default: put_item(OP_BAD, 8'($urandom));
		endcase
	endfunction

	// one cooked line with edits and telnet commands, its terminator (if any) and the reads
	function automatic void gen_cooked_line();
		int n;
		int len;
		int r;
		int t;
		n   = $urandom_range(0, 8);
		len = 0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 55) begin
				put_rx(8'($urandom_range(32, 254)));
				len++;
			end else if (r < 65) begin
				put_rx(r[0] ? CH_DEL : CH_BS);
				if (len > 0)
					len--;
			end else if (r < 72) begin
				put_rx(CH_TAB);
				len++;
			end else if (r < 78) begin
				put_rx(8'($urandom_range(0, 31)));
				len++;
			end else if (r < 84) begin
				put_rx(CH_IAC);
				put_rx(CH_IAC);
				len++;
			end else if (r < 90) begin
				put_rx(CH_IAC);
				put_rx(8'($urandom_range(CH_WILL, CH_DONT)));
				put_rx(8'($urandom));
			end else if (r < 94) begin
				put_rx(CH_IAC);
				put_rx(CH_SB);
				repeat ($urandom_range(0, 3))
					put_rx(8'($urandom_range(0, 254)));
				put_rx(CH_IAC);
				put_rx(CH_SE);
			end else if (r < 97) begin
				put_rx(CH_IAC);
				put_rx(8'($urandom_range(0, 249)));
			end else begin
				put_rx(8'($urandom));
			end
		end
		t = $urandom_range(0, 4);
		case (t)
			0, 1: put_rx(CH_CR);
			2:    put_rx(CH_LF);
			3:    put_rx(CH_EOT);
			default: ;
		endcase
		if (t != 4)
			put_reads(len + 1 + $urandom_range(0, 2));
		if (t == 1)
			put_rx($urandom_range(0, 1) ? CH_LF : CH_NUL);
	endfunction

	function automatic void gen_cooked(int target);
		int base;
		base = link_items.size();
		while (link_items.size() - base < target) begin
			if ($urandom_range(99) < 85)
				gen_cooked_line();
			else
				gen_noise();
		end
	endfunction

	function automatic void gen_raw(int target);
		int base;
		int r;
		base = link_items.size();
		while (link_items.size() - base < target) begin
			r = $urandom_range(99);
			if (r < 50) begin
				put_rx(8'($urandom_range(0, 254)));
				put_reads(1);
			end else if (r < 60) begin
				put_rx(8'($urandom_range(0, 254)));
				put_rx(8'($urandom_range(0, 254)));
				put_reads($urandom_range(1, 2));
			end else if (r < 70) begin
				put_rx(CH_IAC);
				put_rx(CH_IAC);
				put_reads(1);
			end else if (r < 78) begin
				put_rx(CH_IAC);
				put_rx(8'($urandom_range(CH_WILL, CH_DONT)));
				put_rx(8'($urandom));
				put_reads(1);
			end else if (r < 90) begin
				put_reads(1);
			end else begin
				gen_noise();
			end
		end
	endfunction

	// drain whatever line is pending and close any partial one
	function automatic void flush_line();
		put_reads(12);
		put_rx(CH_CR);
		put_reads(12);
	endfunction

	function automatic void gen_directed();
		put_reads(1);
		put_item(OP_BAD, CH_IAC);
		put_rx(CH_BS);
		put_rx(CH_NUL);
		put_rx(8'h41);
		put_rx(CH_TAB);
		put_rx(8'h01);
		put_rx(CH_DEL);
		put_rx(CH_IAC);
		put_rx(CH_IAC);
		put_rx(CH_IAC);
		put_rx(CH_WILL);
		put_rx(8'h01);
		put_rx(CH_IAC);
		put_rx(CH_SB);
		put_rx(8'h18);
		put_rx(CH_IAC);
		put_rx(CH_SE);
		put_rx(CH_IAC);
		put_rx(CH_NOP);
		put_rx(CH_CR);
		put_rx(8'h78);
		put_reads(5);
		put_rx(CH_LF);
		put_rx(CH_EOT);
		put_reads(2);
		put_rx(8'h71);
		put_rx(CH_EOT);
		put_reads(2);
	endfunction

	function automatic void gen_hangup_tail();
		put_reads(12);
		put_rx(CH_EOT);
		put_rx(8'h68);
		put_rx(8'h69);
		put_item(OP_HANGUP, 8'($urandom));
		put_reads(5);
		put_rx(8'h78);
		put_item(OP_HANGUP, 8'($urandom));
		put_item(OP_BAD, 8'($urandom));
		put_rx(CH_CR);
		put_reads(1);
	endfunction

	task automatic pace(int idle, int stall);
		idle_pct  = idle;
		stall_pct = stall;
	endtask

	task automatic settle();
		while (link_items.size() != 0 || due_results.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_raw_mode(logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		raw_mode_q = v;
		@(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_raw_mode(1'b0);

		pace(0, 0);
		gen_directed();
		settle();

		pace(59, 0);
		gen_cooked(25);
		settle();

		pace(0, 59);
		hold_req++;
		gen_cooked(25);
		settle();

		pace(14, 14);
		gen_cooked(25);
		flush_line();
		settle();

		// partial cooked line, then raw bytes join it
		put_rx(8'h61);
		put_rx(8'h62);
		settle();
		write_raw_mode(1'b1);
		pace(0, 0);
		put_rx(8'h63);
		put_reads(4);
		gen_raw(30);
		settle();

		// CR ends a cooked line; the LF that follows in raw mode is absorbed
		write_raw_mode(1'b0);
		pace(14, 14);
		flush_line();
		put_rx(8'h70);
		put_rx(CH_CR);
		put_reads(3);
		settle();
		write_raw_mode(1'b1);
		put_rx(CH_LF);
		put_reads(1);
		gen_raw(15);
		settle();

		write_raw_mode(1'b0);
		pace(59, 59);
		gen_cooked(20);
		gen_hangup_tail();
		settle();
		repeat (16) @(posedge clk);

		$display("%0d items transferred, %0d results checked", n_items, n_results);
		$display("kinds seen: accept %0d echo %0d data %0d eof %0d wait %0d refuse %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
			kind_seen[5]);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: telnet_console_line_cooker.f
rtl/tcl_pkg.sv
rtl/tcl_line_ram.sv
rtl/tcl_ctrl.sv
rtl/tcl_out.sv
rtl/telnet_console_line_cooker.sv
test/tb_top.sv
